FILE: design/rme_pkg.sv
// shared types, constants and register codes for the modular exponentiation block
package rme_pkg;

  localparam int WORD_BITS = 16;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int IDX_BITS  = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [IDX_BITS-1:0]  reg_idx_t;

  localparam reg_idx_t REG_MODULUS  = 2'd0;
  localparam reg_idx_t REG_PUB_EXP  = 2'd1;
  localparam reg_idx_t REG_PRIV_EXP = 2'd2;

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  localparam cnt_t CNT_LAST = cnt_t'(WORD_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_SCAN,
    S_SQUARE,
    S_MULT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t m;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t product;
  } mul_rsp_t;

endpackage

FILE: design/rme_modmul.sv
// shift-and-add modular multiplier, one multiplier bit per cycle
module rme_modmul import rme_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  word_t r;
  word_t a_q;
  word_t b_q;
  word_t m_q;
  cnt_t  cnt;
  logic  busy;
  logic  done;

  logic [WORD_BITS:0] dbl;
  logic [WORD_BITS:0] sum;
  word_t              dbl_red;
  word_t              r_next;

  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? word_t'(dbl - {1'b0, m_q}) : word_t'(dbl);
    sum     = {1'b0, dbl_red} + {1'b0, a_q};
    if (b_q[WORD_BITS-1]) begin
      r_next = (sum >= {1'b0, m_q}) ? word_t'(sum - {1'b0, m_q}) : word_t'(sum);
    end else begin
      r_next = dbl_red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + cnt_t'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      r   <= '0;
      a_q <= req.a;
      b_q <= req.b;
      m_q <= req.m;
    end else if (busy) begin
      r   <= r_next;
      b_q <= {b_q[WORD_BITS-2:0], 1'b0};
    end
  end

  assign rsp.done    = done;
  assign rsp.product = r;

endmodule

FILE: design/rme_seq.sv
// square-and-multiply sequencer with input handshake and result register
module rme_seq import rme_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     req_type,
  input  word_t    message_value,
  output logic     out_valid,
  input  logic     out_ready,
  output word_t    result_value,
  input  word_t    modulus,
  input  word_t    public_exponent,
  input  word_t    private_exponent,
  output mul_req_t mul_req,
  input  mul_rsp_t mul_rsp
);

  state_t state;
  state_t state_next;
  word_t  msg;
  word_t  base;
  word_t  acc;
  word_t  exp_q;
  cnt_t   bit_idx;
  logic   started;
  word_t  result;
  logic   res_valid;
  logic   reduce_go;

  logic   cur_bit;
  logic   last_bit;
  logic   accept;
  logic   out_free;
  logic   reduce_start;

  assign cur_bit  = exp_q[bit_idx];
  assign last_bit = (bit_idx == '0);
  assign accept   = in_valid && in_ready;
  assign out_free = !res_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (modulus < word_t'(2)) ? S_FINISH : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (mul_rsp.done) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (started) begin
          state_next = S_SQUARE;
        end else if (last_bit) begin
          state_next = S_FINISH;
        end
      end
      S_SQUARE: begin
        if (mul_rsp.done) begin
          if (cur_bit) begin
            state_next = S_MULT;
          end else if (last_bit) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_MULT: begin
        if (mul_rsp.done) begin
          state_next = last_bit ? S_FINISH : S_SCAN;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = acc;
    mul_req.b     = acc;
    mul_req.m     = modulus;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_REDUCE: begin
        mul_req.start = reduce_go;
        mul_req.a     = word_t'(1);
        mul_req.b     = msg;
      end
      S_SCAN: begin
        mul_req.start = started;
      end
      S_SQUARE: begin
        mul_req.start = mul_rsp.done && cur_bit;
        mul_req.a     = mul_rsp.product;
        mul_req.b     = base;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && out_free) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // reduction of the message runs as 1 * msg through the multiplier
  assign reduce_start = accept && (modulus >= word_t'(2));

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          msg     <= message_value;
          exp_q   <= (req_type == REQ_DECRYPT) ? private_exponent : public_exponent;
          acc     <= (modulus < word_t'(2)) ? '0 : word_t'(1);
          bit_idx <= CNT_LAST;
          started <= 1'b0;
        end
      end
      S_REDUCE: begin
        if (mul_rsp.done) begin
          base <= mul_rsp.product;
        end
      end
      S_SCAN: begin
        if (!started) begin
          if (cur_bit) begin
            acc     <= base;
            started <= 1'b1;
          end
          if (!last_bit) begin
            bit_idx <= bit_idx - cnt_t'(1);
          end
        end
      end
      S_SQUARE: begin
        if (mul_rsp.done) begin
          acc <= mul_rsp.product;
          if (!cur_bit && !last_bit) begin
            bit_idx <= bit_idx - cnt_t'(1);
          end
        end
      end
      S_MULT: begin
        if (mul_rsp.done) begin
          acc <= mul_rsp.product;
          if (!last_bit) begin
            bit_idx <= bit_idx - cnt_t'(1);
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          result <= acc;
        end
      end
      default: begin
      end
    endcase
  end

  // the reduction pass is launched in the cycle after acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_go <= 1'b0;
    end else begin
      reduce_go <= reduce_start;
    end
  end

  assign out_valid    = res_valid;
  assign result_value = result;

endmodule

FILE: design/rsa_modular_exponentiation.sv
// top level of the modular exponentiation block: registers, sequencer, multiplier
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    req_type, message_value
//   out      source     out_valid / out_ready  result_value
//   cfg      sink       cfg_wr_en              cfg_index, cfg_wr_data
//
// one beat runs from acceptance to the output register through a reduction of the message,
// a scan to the exponent's leading one, then a squaring for each further exponent bit and
// a multiply for each further one bit; a modulus below two goes straight to the result.
// all products go through the shared multiplier, one shift-and-add step per multiplier bit.
// in_ready is low from acceptance until the result is loaded into the output register.
// a result stalled on out_ready holds the next beat in its last step.
// reset is synchronous; registers return to modulus 2 and exponents 1.
module rsa_modular_exponentiation import rme_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     req_type,
  input  word_t    message_value,
  output logic     out_valid,
  input  logic     out_ready,
  output word_t    result_value,
  input  logic     cfg_wr_en,
  input  reg_idx_t cfg_index,
  input  word_t    cfg_wr_data
);

  word_t    modulus;
  word_t    public_exponent;
  word_t    private_exponent;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= word_t'(2);
      public_exponent  <= word_t'(1);
      private_exponent <= word_t'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODULUS:  modulus          <= cfg_wr_data;
        REG_PUB_EXP:  public_exponent  <= cfg_wr_data;
        REG_PRIV_EXP: private_exponent <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  rme_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .message_value    (message_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_value     (result_value),
    .modulus          (modulus),
    .public_exponent  (public_exponent),
    .private_exponent (private_exponent),
    .mul_req          (mul_req),
    .mul_rsp          (mul_rsp)
  );

  rme_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

endmodule

FILE: design/rme_checker.sv
// port-level checks for the modular exponentiation block and their binding
module rme_checker import rme_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input word_t result_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("result beat dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a beat is in work");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded without returning to idle");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset leaves the block busy or a result pending");

endmodule

bind rsa_modular_exponentiation rme_checker u_rme_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_value (result_value)
);
